### src/bclru_pkg.sv
`default_nettype none

package bclru_pkg;

   localparam int BLOCK_W    = 32;
   localparam int TICK_W     = 32;
   localparam int INTERVAL_W = 16;
   localparam int SLOT_W     = 4;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 2;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10;

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_FLUSH = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_WRITEBACK  = 2'd0,
      KIND_READ       = 2'd1,
      KIND_WRITE      = 2'd2,
      KIND_FLUSH_DONE = 2'd3
   } kind_type;

   typedef struct packed {
      op_type               op;
      logic [BLOCK_W-1:0]   blk;
   } q_entry_type;

endpackage

`default_nettype wire

### src/bclru_if.sv
`default_nettype none

interface bclru_req_if
   import bclru_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [BLOCK_W-1:0] block_id;

   modport source (output valid, output opcode, output block_id, input ready);
   modport sink   (input valid, input opcode, input block_id, output ready);
endinterface

interface bclru_rsp_if
   import bclru_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [SLOT_W-1:0]  slot;
   logic [BLOCK_W-1:0] result_block;
   logic               hit;
   logic               fill;
   logic               last;

   modport source (output valid, output kind, output slot, output result_block,
                   output hit, output fill, output last, input ready);
   modport sink   (input valid, input kind, input slot, input result_block,
                   input hit, input fill, input last, output ready);
endinterface

`default_nettype wire

### src/block_cache_lru_write_back.sv
// Fully associative block-cache directory, LRU with clean-first eviction and
// timed write-back of aged dirty slots.
// req_bus: one beat per access (opcode read, write, flush all, tick; block_id).
// rsp_bus: result beats; writebacks come first, the final beat of each read,
//   write or flush has last set. A tick produces no beat.
// csr_wr_en / csr_wr_data: write the writeback interval while idle.
// Beats land in a QUEUE_DEPTH entry queue; a back-end sequencer retires them
// one at a time, taking the next only once back in idle. A tick is counted in
// idle; any other item goes to the writeback state, which emits the aged dirty
// slots (for a flush, all dirty slots, then the done beat). A miss then picks
// its victim; the act state writes back a dirty victim, then emits the result.
// The sequencer emits at most one beat per cycle, and none while rsp_bus stalls.
// Reset leaves every slot invalid, the tick count at zero, the interval at 10
// and the queue empty; no clearing pass is needed.
// A stalled rsp_bus holds its beat in the output register; the sequencer waits
// and req_bus.ready drops once the queue is full.
`default_nettype none

module block_cache_lru_write_back
   import bclru_pkg::*;
#(
   parameter int ENTRIES     = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bclru_req_if.sink                  req_bus,
   bclru_rsp_if.source                rsp_bus,
   input  wire logic                  csr_wr_en,
   input  wire logic [INTERVAL_W-1:0] csr_wr_data
);

   q_entry_type head;
   logic        head_valid;
   logic        head_pop;

   bclru_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   bclru_back #(
      .ENTRIES (ENTRIES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (head_valid),
      .head_pop    (head_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_bus     (rsp_bus)
   );

endmodule

`default_nettype wire

### src/bclru_front.sv
`default_nettype none

module bclru_front
   import bclru_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bclru_req_if.sink   req_bus,
   output q_entry_type head,
   output logic        head_valid,
   input  wire logic   head_pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   q_entry_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;
   q_entry_type        push_entry;

   assign req_bus.ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid    = (count_ff != '0);
   assign head          = entry_ff[rd_ptr_ff];

   assign push = req_bus.valid && req_bus.ready;
   assign pop  = head_pop && head_valid;

   // classify the beat
   always_comb begin
      push_entry.op  = op_type'(req_bus.opcode);
      push_entry.blk = req_bus.block_id;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### src/bclru_back.sv
`default_nettype none

module bclru_back
   import bclru_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire q_entry_type           head,
   input  wire logic                  head_valid,
   output logic                       head_pop,
   input  wire logic                  csr_wr_en,
   input  wire logic [INTERVAL_W-1:0] csr_wr_data,
   bclru_rsp_if.source                rsp_bus
);

   localparam int IDX_W = $clog2(ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WBACK = 4'b0010,
      ST_PICK  = 4'b0100,
      ST_ACT   = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [BLOCK_W-1:0]      blk_ff, blk_in;
   logic [ENTRIES-1:0]      mask_ff, mask_in;
   logic [ENTRIES-1:0]      hit_ff, hit_in;
   logic [ENTRIES-1:0]      crank_ff, crank_in;
   logic [IDX_W-1:0]        victim_ff, victim_in;
   logic [TICK_W-1:0]       tick_ff, tick_in;
   logic [INTERVAL_W-1:0]   interval_ff, interval_in;

   logic [ENTRIES-1:0]      valid_ff, valid_in;
   logic [ENTRIES-1:0]      dirty_ff, dirty_in;
   logic [BLOCK_W-1:0]      tag_ff   [ENTRIES];
   logic [BLOCK_W-1:0]      tag_in   [ENTRIES];
   logic [TICK_W-1:0]       stamp_ff [ENTRIES];
   logic [TICK_W-1:0]       stamp_in [ENTRIES];
   logic [IDX_W-1:0]        rank_ff  [ENTRIES];
   logic [IDX_W-1:0]        rank_in  [ENTRIES];

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [BLOCK_W-1:0]      rsp_block_ff, rsp_block_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic                    rsp_fill_ff, rsp_fill_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    out_free;
   logic [ENTRIES-1:0]      age_due;
   logic [ENTRIES-1:0]      head_hit;
   logic [IDX_W-1:0]        wb_idx;
   logic                    mask_any;
   logic [IDX_W-1:0]        hit_idx;
   logic                    hit_any;
   logic [IDX_W-1:0]        first_inv;
   logic                    inv_any;
   logic [ENTRIES-1:0]      crank_calc;
   logic [IDX_W-1:0]        top_rank;
   logic [IDX_W-1:0]        rank_idx;
   logic [IDX_W-1:0]        victim_calc;
   logic [IDX_W-1:0]        tgt;
   logic [IDX_W-1:0]        old_rank;
   logic [TICK_W-1:0]       interval_ext;

   function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, idx};
      return ext[SLOT_W-1:0];
   endfunction

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign interval_ext = {{(TICK_W - INTERVAL_W){1'b0}}, interval_ff};

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_kind_ff;
   assign rsp_bus.slot         = rsp_slot_ff;
   assign rsp_bus.result_block = rsp_block_ff;
   assign rsp_bus.hit          = rsp_hit_ff;
   assign rsp_bus.fill         = rsp_fill_ff;
   assign rsp_bus.last         = rsp_last_ff;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         age_due[i]  = (tick_ff - stamp_ff[i]) >= interval_ext;
         head_hit[i] = valid_ff[i] && (tag_ff[i] == head.blk);
      end
   end

   always_comb begin
      wb_idx    = '0;
      hit_idx   = '0;
      first_inv = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            wb_idx = IDX_W'(i);
         end
         if (hit_ff[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            first_inv = IDX_W'(i);
         end
      end
      mask_any = |mask_ff;
      hit_any  = |hit_ff;
      inv_any  = !(&valid_ff);
   end

   always_comb begin
      for (int r = 0; r < ENTRIES; r++) begin
         crank_calc[r] = 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (valid_ff[i] && !dirty_ff[i] && (rank_ff[i] == IDX_W'(r))) begin
               crank_calc[r] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      top_rank = IDX_W'(ENTRIES - 1);
      for (int r = ENTRIES - 1; r >= 0; r--) begin
         if (crank_ff[r] && (crank_ff >> r) == ENTRIES'(1)) begin
            top_rank = IDX_W'(r);
         end
      end
      rank_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (rank_ff[i] == top_rank)) begin
            rank_idx = IDX_W'(i);
         end
      end
      victim_calc = inv_any ? first_inv : rank_idx;
   end

   assign tgt      = hit_any ? hit_idx : victim_ff;
   assign old_rank = valid_ff[tgt] ? rank_ff[tgt] : IDX_W'(ENTRIES - 1);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      blk_in       = blk_ff;
      mask_in      = mask_ff;
      hit_in       = hit_ff;
      crank_in     = crank_ff;
      victim_in    = victim_ff;
      tick_in      = tick_ff;
      interval_in  = interval_ff;
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      tag_in       = tag_ff;
      stamp_in     = stamp_ff;
      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_block_in = rsp_block_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_fill_in  = rsp_fill_ff;
      rsp_last_in  = rsp_last_ff;
      head_pop     = 1'b0;

      if (csr_wr_en) begin
         interval_in = csr_wr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (head.op == OP_TICK) begin
                  tick_in = tick_ff + TICK_W'(1);
               end else begin
                  op_in    = head.op;
                  blk_in   = head.blk;
                  mask_in  = valid_ff & dirty_ff &
                             ((head.op == OP_FLUSH) ? {ENTRIES{1'b1}} : age_due);
                  hit_in   = head_hit;
                  state_in = ST_WBACK;
               end
            end
         end
         ST_WBACK: begin
            if (mask_any) begin
               if (out_free) begin
                  rsp_valid_in     = 1'b1;
                  rsp_kind_in      = KIND_WRITEBACK;
                  rsp_slot_in      = to_slot(wb_idx);
                  rsp_block_in     = tag_ff[wb_idx];
                  rsp_hit_in       = 1'b0;
                  rsp_fill_in      = 1'b0;
                  rsp_last_in      = 1'b0;
                  dirty_in[wb_idx] = 1'b0;
                  mask_in[wb_idx]  = 1'b0;
               end
            end else if (op_ff == OP_FLUSH) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FLUSH_DONE;
                  rsp_slot_in  = '0;
                  rsp_block_in = '0;
                  rsp_hit_in   = 1'b0;
                  rsp_fill_in  = 1'b0;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (hit_any) begin
               state_in = ST_ACT;
            end else begin
               crank_in = crank_calc;
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            victim_in = victim_calc;
            state_in  = ST_ACT;
         end
         ST_ACT: begin
            if (out_free) begin
               if (!hit_any && valid_ff[tgt] && dirty_ff[tgt]) begin
                  // evict the dirty victim first
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_WRITEBACK;
                  rsp_slot_in   = to_slot(tgt);
                  rsp_block_in  = tag_ff[tgt];
                  rsp_hit_in    = 1'b0;
                  rsp_fill_in   = 1'b0;
                  rsp_last_in   = 1'b0;
                  dirty_in[tgt] = 1'b0;
               end else begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if ((IDX_W'(i) != tgt) && valid_ff[i] && (rank_ff[i] < old_rank) &&
                         (rank_ff[i] < IDX_W'(ENTRIES - 1))) begin
                        rank_in[i] = rank_ff[i] + IDX_W'(1);
                     end
                  end
                  rank_in[tgt] = '0;
                  if (hit_any) begin
                     if ((op_ff == OP_WRITE) && !dirty_ff[tgt]) begin
                        dirty_in[tgt] = 1'b1;
                        stamp_in[tgt] = tick_ff;
                     end
                  end else begin
                     valid_in[tgt] = 1'b1;
                     tag_in[tgt]   = blk_ff;
                     dirty_in[tgt] = (op_ff == OP_WRITE);
                     if (op_ff == OP_WRITE) begin
                        stamp_in[tgt] = tick_ff;
                     end
                  end
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = (op_ff == OP_WRITE) ? KIND_WRITE : KIND_READ;
                  rsp_slot_in  = to_slot(tgt);
                  rsp_block_in = blk_ff;
                  rsp_hit_in   = hit_any;
                  rsp_fill_in  = !hit_any && (op_ff == OP_READ);
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= '0;
         interval_ff  <= INTERVAL_RESET;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         interval_ff  <= interval_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      blk_ff       <= blk_in;
      mask_ff      <= mask_in;
      hit_ff       <= hit_in;
      crank_ff     <= crank_in;
      victim_ff    <= victim_in;
      tag_ff       <= tag_in;
      stamp_ff     <= stamp_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_block_ff <= rsp_block_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_fill_ff  <= rsp_fill_in;
      rsp_last_ff  <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_dirty_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (dirty_ff & ~valid_ff) == '0)
      else $error("dirty slot is not valid");

   a_writeback_cleans: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WBACK && mask_any && out_free) |=> !dirty_ff[$past(wb_idx)])
      else $error("written back slot still dirty");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACT) |-> $onehot0(hit_ff))
      else $error("block cached in more than one slot");
`endif

endmodule

`default_nettype wire

### bench/tb_block_cache_lru_write_back.sv
`default_nettype none

module tb_block_cache_lru_write_back;
   import bclru_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 16;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE      = 24;
   localparam int N_PHASES    = 6;
   localparam int PHASE_ITEMS = 72;

   typedef struct packed {
      kind_type              kind;
      logic [SLOT_W-1:0]     slot;
      logic [BLOCK_W-1:0]    blk;
      logic                  hit;
      logic                  fill;
      logic                  last;
   } beat_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [INTERVAL_W-1:0] csr_wr_data = '0;

   bclru_req_if req_if ();
   bclru_rsp_if rsp_if ();

   block_cache_lru_write_back uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // directory image
   logic                  d_valid [SLOTS];
   logic                  d_dirty [SLOTS];
   logic [BLOCK_W-1:0]    d_tag   [SLOTS];
   logic [TICK_W-1:0]     d_stamp [SLOTS];
   logic [SLOT_W-1:0]     d_rank  [SLOTS];
   logic [TICK_W-1:0]     d_ticks = '0;
   logic [INTERVAL_W-1:0] d_interval = INTERVAL_RESET;

   q_entry_type access_backlog [$];
   beat_type    owed_beats [$];

   int  n_accepted = 0;
   int  n_beats = 0;
   int  n_errors = 0;
   int  n_settings = 0;
   int  quiet_cycles = 0;
   int  src_gap = 0;
   int  sink_gap = 0;
   int  hold_cnt = 0;
   bit  hold_req = 0;
   bit  calm = 0;
   q_entry_type cur_item;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         d_valid[i] = 1'b0;
         d_dirty[i] = 1'b0;
         d_tag[i]   = '0;
         d_stamp[i] = '0;
         d_rank[i]  = '0;
      end
      req_if.valid    = 1'b0;
      req_if.opcode   = '0;
      req_if.block_id = '0;
      rsp_if.ready    = 1'b0;
   end

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void owe(kind_type k, int s, logic [BLOCK_W-1:0] b,
                               logic h, logic f, logic l);
      beat_type bt;
      bt.kind = k;
      bt.slot = SLOT_W'(s);
      bt.blk  = b;
      bt.hit  = h;
      bt.fill = f;
      bt.last = l;
      owed_beats.push_back(bt);
   endfunction

   function automatic void writeback_slot(int s);
      owe(KIND_WRITEBACK, s, d_tag[s], 1'b0, 1'b0, 1'b0);
      d_dirty[s] = 1'b0;
   endfunction

   function automatic void promote(int s);
      int old;
      old = d_valid[s] ? int'(d_rank[s]) : SLOTS - 1;
      for (int i = 0; i < SLOTS; i++)
         if (i != s && d_valid[i] && int'(d_rank[i]) < old && int'(d_rank[i]) < SLOTS - 1)
            d_rank[i] = d_rank[i] + 1'b1;
      d_rank[s] = '0;
   endfunction

   function automatic void directory_step(q_entry_type it);
      int                hit_slot;
      int                victim;
      int                clean_lru;
      int                dirty_lru;
      logic [TICK_W-1:0] age;
      hit_slot  = -1;
      victim    = -1;
      clean_lru = -1;
      dirty_lru = -1;
      case (it.op)
         OP_TICK: begin
            d_ticks = d_ticks + 1'b1;
         end
         OP_FLUSH: begin
            for (int i = 0; i < SLOTS; i++)
               if (d_valid[i] && d_dirty[i])
                  writeback_slot(i);
            owe(KIND_FLUSH_DONE, 0, '0, 1'b0, 1'b0, 1'b1);
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               age = d_ticks - d_stamp[i];
               if (d_valid[i] && d_dirty[i] && age >= TICK_W'(d_interval))
                  writeback_slot(i);
            end
            for (int i = 0; i < SLOTS; i++)
               if (hit_slot < 0 && d_valid[i] && d_tag[i] == it.blk)
                  hit_slot = i;
            if (hit_slot >= 0) begin
               if (it.op == OP_WRITE && !d_dirty[hit_slot]) begin
                  d_dirty[hit_slot] = 1'b1;
                  d_stamp[hit_slot] = d_ticks;
               end
               promote(hit_slot);
               owe(it.op == OP_WRITE ? KIND_WRITE : KIND_READ, hit_slot, it.blk,
                   1'b1, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (victim < 0) begin
                     if (!d_valid[i])
                        victim = i;
                     else if (d_dirty[i]) begin
                        if (dirty_lru < 0 || d_rank[i] > d_rank[dirty_lru])
                           dirty_lru = i;
                     end else begin
                        if (clean_lru < 0 || d_rank[i] > d_rank[clean_lru])
                           clean_lru = i;
                     end
                  end
               end
               if (victim < 0)
                  victim = (clean_lru >= 0) ? clean_lru : ((dirty_lru >= 0) ? dirty_lru : 0);
               if (d_valid[victim] && d_dirty[victim])
                  writeback_slot(victim);
               promote(victim);
               d_valid[victim] = 1'b1;
               d_tag[victim]   = it.blk;
               if (it.op == OP_WRITE) begin
                  d_dirty[victim] = 1'b1;
                  d_stamp[victim] = d_ticks;
                  owe(KIND_WRITE, victim, it.blk, 1'b0, 1'b0, 1'b1);
               end else begin
                  d_dirty[victim] = 1'b0;
                  owe(KIND_READ, victim, it.blk, 1'b0, 1'b1, 1'b1);
               end
            end
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0h actual %0h", name, exp_v, act_v);
         n_errors++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin : drive_req
      bit nv;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         nv = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            directory_step(cur_item);
            n_accepted++;
            nv = 1'b0;
            if (!calm && $urandom_range(0, 99) < 10)
               src_gap = $urandom_range(1, 17);
         end
         if (!nv) begin
            if (src_gap > 0) begin
               src_gap--;
            end else if (access_backlog.size() > 0) begin
               cur_item = access_backlog.pop_front();
               req_if.opcode   <= cur_item.op;
               req_if.block_id <= cur_item.blk;
               nv = 1'b1;
            end
         end
         req_if.valid <= nv;
      end
   end

   // result monitor and ready
   always @(posedge clock) begin : watch_rsp
      beat_type bt;
      bit       rdy;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            n_beats++;
            if (owed_beats.size() == 0) begin
               $error("unexpected beat kind %0d slot %0d block %0h",
                      rsp_if.kind, rsp_if.slot, rsp_if.result_block);
               n_errors++;
            end else begin
               bt = owed_beats.pop_front();
               check_field("kind", 32'(bt.kind), 32'(rsp_if.kind));
               check_field("slot", 32'(bt.slot), 32'(rsp_if.slot));
               check_field("result_block", bt.blk, rsp_if.result_block);
               check_field("hit", 32'(bt.hit), 32'(rsp_if.hit));
               check_field("fill", 32'(bt.fill), 32'(rsp_if.fill));
               check_field("last", 32'(bt.last), 32'(rsp_if.last));
            end
         end
         if (hold_req) begin
            hold_req = 0;
            hold_cnt = HOLD_CYCLES;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rdy = 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
            if (!calm && $urandom_range(0, 99) < 8)
               sink_gap = $urandom_range(1, 17);
         end
         rsp_if.ready <= rdy;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      @(negedge clock);
      while (quiet_cycles < QUIET_LIMIT)
         @(negedge clock);
      $display("TEST FAILED");
      $finish;
   end

   function automatic void queue_access(op_type o, logic [BLOCK_W-1:0] b);
      q_entry_type it;
      it.op  = o;
      it.blk = b;
      access_backlog.push_back(it);
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (access_backlog.size() > 0 || req_if.valid || owed_beats.size() > 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_interval(logic [INTERVAL_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      d_interval = v;
      n_settings++;
   endtask

   initial begin : sequencer
      logic [INTERVAL_W-1:0] phase_interval [N_PHASES];
      logic [BLOCK_W-1:0]    pool [$];
      int                    pool_size;
      int                    flush_pct;
      int                    r;
      op_type                o;
      logic [BLOCK_W-1:0]    b;

      phase_interval[0] = 16'd0;
      phase_interval[1] = 16'hFFFF;
      phase_interval[2] = 16'd1;
      phase_interval[3] = 16'd3;
      phase_interval[4] = INTERVAL_W'($urandom_range(2, 40));
      phase_interval[5] = INTERVAL_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      queue_access(OP_READ,  32'h0000_0000);
      queue_access(OP_READ,  32'h0000_0000);
      queue_access(OP_WRITE, 32'hFFFF_FFFF);
      queue_access(OP_WRITE, 32'hFFFF_FFFF);
      queue_access(OP_WRITE, 32'h0000_0000);
      queue_access(OP_FLUSH, 32'h0000_0000);
      queue_access(OP_FLUSH, 32'hFFFF_FFFF);
      queue_access(OP_TICK,  32'hFFFF_FFFF);
      queue_access(OP_READ,  32'hAAAA_AAAA);
      queue_access(OP_WRITE, 32'h5555_5555);
      queue_access(OP_TICK,  32'h0000_0000);
      queue_access(OP_READ,  32'h5555_5555);
      queue_access(OP_WRITE, 32'hAAAA_AAAA);
      queue_access(OP_READ,  32'h0000_0000);
      queue_access(OP_FLUSH, 32'h1234_5678);
      queue_access(OP_READ,  32'hFFFF_FFFF);
      wait_drained();

      for (int ph = 0; ph < N_PHASES; ph++) begin
         set_interval(phase_interval[ph]);
         @(negedge clock);
         if (ph == N_PHASES - 1)
            calm = 1;
         pool.delete();
         pool_size = $urandom_range(18, 28);
         for (int k = 0; k < pool_size; k++)
            pool.push_back($urandom());
         flush_pct = (ph == 1) ? 1 : 6;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < flush_pct)
               o = OP_FLUSH;
            else if (r < flush_pct + 22)
               o = OP_TICK;
            else if (r < 61)
               o = OP_WRITE;
            else
               o = OP_READ;
            if ($urandom_range(0, 9) == 0 || o == OP_TICK || o == OP_FLUSH)
               b = $urandom();
            else
               b = pool[$urandom_range(0, pool_size - 1)];
            queue_access(o, b);
         end
         if (ph == 1)
            hold_req = 1;
         wait_drained();
      end

      $display("covered %0d request beats and %0d result beats over %0d interval settings,",
               n_accepted, n_beats, n_settings);
      $display("including a long result stall that backed up the request channel");
      if (n_errors == 0 && owed_beats.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
src/bclru_pkg.sv
src/bclru_if.sv
src/bclru_front.sv
src/bclru_back.sv
src/block_cache_lru_write_back.sv
bench/tb_block_cache_lru_write_back.sv
